// ===== rtl/vlrq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the variable-length ring queue.
// No dependencies; used by variable_length_ring_queue_top and the testbench.
package vlrq_pkg;

	localparam int RING_BYTES    = 4096;
	localparam int HEADER_BYTES  = 8;
	localparam int CONTROL_BYTES = 16;

	localparam int ADDR_W  = $clog2(RING_BYTES);
	localparam int OFF_W   = ADDR_W + 1;
	localparam int SUM_W   = OFF_W + 1;
	localparam int CFG_W   = 13;
	localparam int CALC_W  = (SUM_W > CFG_W + 1) ? SUM_W : CFG_W + 1;
	localparam int LEN_W   = 13;
	localparam int HDR_W   = LEN_W + 1;
	localparam int FIELD_W = 12;

	localparam logic [FIELD_W-1:0] COUNT_MAX      = '1;
	localparam logic [CFG_W-1:0]   RING_LEN_RESET = CFG_W'(4096);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP_RD,
		ST_POP_EV
	} state_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

endpackage

// ===== rtl/variable_length_ring_queue_top.sv =====
`timescale 1ns / 1ps
// Variable-length ring queue: head/tail bookkeeping for a byte ring of blocks.
// Depends on vlrq_pkg and vlrq_ram.

// The block tracks write and read byte offsets into a ring whose first
// CONTROL_BYTES bytes are reserved, and keeps every block header in a header
// RAM indexed by offset modulo RING_BYTES. A push beat that fits leaves its
// header at the write offset; one that would reach the ring end leaves a
// padding header (when one fits) and, unless the read offset sits at the ring
// start, retries once from the ring start. A pop beat skips padding or a
// too-short tail end the same way and returns the oldest block. Every input
// beat yields exactly one result beat. A push is decided in ST_PUSH, which a
// wrap repeats; a pop reads a header in ST_POP_RD and decides in ST_POP_EV,
// and a wrap goes through both again, because each look at a header goes
// through the single registered read port of the header RAM. One command is
// in flight at a time; the result sits in an output register, so the next
// command is accepted while a result still waits to be taken. The header RAM
// is not cleared after reset. The ring_length register may be written only
// while no command is outstanding; values above RING_BYTES act as RING_BYTES.
module variable_length_ring_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vlrq_pkg::CFG_W-1:0]    ring_length,
	// Command channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [vlrq_pkg::FIELD_W-1:0]  push_length,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [vlrq_pkg::FIELD_W-1:0]  block_offset,
	output logic [vlrq_pkg::FIELD_W-1:0]  block_length,
	output logic [vlrq_pkg::FIELD_W-1:0]  block_count
);

	localparam int CW = vlrq_pkg::CALC_W;

	vlrq_pkg::state_t                 state_q, state_d;
	logic [vlrq_pkg::CFG_W-1:0]       ring_length_q;
	logic [vlrq_pkg::OFF_W-1:0]       wr_q, rd_q;
	logic [vlrq_pkg::FIELD_W-1:0]     cnt_q;
	logic                             cmd_q;
	logic [vlrq_pkg::FIELD_W-1:0]     len_q;
	logic                             pass_q;

	logic                             out_valid_q, ok_q;
	logic [vlrq_pkg::FIELD_W-1:0]     offset_q, length_q, count_q;

	// Header RAM ports.
	logic                             mem_we;
	logic [vlrq_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
	logic [vlrq_pkg::HDR_W-1:0]       mem_wdata, mem_rdata;

	// Working values, all in one wide enough width so no compare overflows.
	logic [CW-1:0] lim, w, r, lenx, hdr, ctl, word_len;
	logic          ge, over, pad_fits, r_start, hits_read, is_short;
	logic          gt, lt, too_close, tail_short, is_pad;

	// Step decision.
	logic          done, step_ok, wrap_w, wrap_r, retry, pad_we;
	logic          slot_free, adv, accept;

	assign lim = (CW'(ring_length_q) > CW'(vlrq_pkg::RING_BYTES)) ?
		CW'(vlrq_pkg::RING_BYTES) : CW'(ring_length_q);
	assign w        = CW'(wr_q);
	assign r        = CW'(rd_q);
	assign lenx     = CW'(len_q);
	assign hdr      = CW'(vlrq_pkg::HEADER_BYTES);
	assign ctl      = CW'(vlrq_pkg::CONTROL_BYTES);
	assign word_len = CW'(mem_rdata[vlrq_pkg::LEN_W-1:0]);

	assign is_short  = len_q < vlrq_pkg::FIELD_W'(vlrq_pkg::HEADER_BYTES);
	assign ge        = w >= r;
	assign over      = (w + lenx) >= lim;
	assign pad_fits  = (w + hdr) <= lim;
	assign r_start   = r == ctl;
	assign hits_read = (w + lenx) >= r;

	assign gt         = w > r;
	assign lt         = w < r;
	assign too_close  = w < (r + hdr);
	assign tail_short = lim < (r + hdr);
	assign is_pad     = mem_rdata[vlrq_pkg::HDR_W-1];

	assign slot_free = !out_valid_q || out_ready;
	assign adv       = slot_free && (state_q == vlrq_pkg::ST_PUSH ||
		state_q == vlrq_pkg::ST_POP_EV);
	assign accept    = in_valid && in_ready;

	// What one pass of the current command does. A wrap moves the offset to
	// the ring start; only one wrap is allowed, so a second one fails.
	always_comb begin
		done    = 1'b0;
		step_ok = 1'b0;
		wrap_w  = 1'b0;
		wrap_r  = 1'b0;
		retry   = 1'b0;
		pad_we  = 1'b0;
		unique case (state_q)
			vlrq_pkg::ST_PUSH: begin
				if (is_short) begin
					done = 1'b1;
				end else if (ge && over) begin
					pad_we = pad_fits;
					if (r_start) begin
						done = 1'b1;
					end else begin
						wrap_w = 1'b1;
						done   = pass_q;
						retry  = !pass_q;
					end
				end else if (!ge && hits_read) begin
					done = 1'b1;
				end else begin
					done    = 1'b1;
					step_ok = 1'b1;
				end
			end
			vlrq_pkg::ST_POP_EV: begin
				if (gt) begin
					done    = 1'b1;
					step_ok = !too_close;
				end else if (lt) begin
					if (tail_short || is_pad) begin
						wrap_r = 1'b1;
						done   = pass_q;
						retry  = !pass_q;
					end else begin
						done    = 1'b1;
						step_ok = 1'b1;
					end
				end else begin
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vlrq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (command == vlrq_pkg::CMD_POP) ?
						vlrq_pkg::ST_POP_RD : vlrq_pkg::ST_PUSH;
				end
			end
			vlrq_pkg::ST_PUSH: begin
				if (adv && done) begin
					state_d = vlrq_pkg::ST_IDLE;
				end
			end
			vlrq_pkg::ST_POP_RD: begin
				state_d = vlrq_pkg::ST_POP_EV;
			end
			vlrq_pkg::ST_POP_EV: begin
				if (adv) begin
					state_d = done ? vlrq_pkg::ST_IDLE : vlrq_pkg::ST_POP_RD;
				end
			end
			default: begin
				state_d = vlrq_pkg::ST_IDLE;
			end
		endcase
	end

	// State machine outputs: handshakes and header RAM accesses.
	always_comb begin
		in_ready  = state_q == vlrq_pkg::ST_IDLE;
		cfg_ready = 1'b1;
		mem_we    = adv && state_q == vlrq_pkg::ST_PUSH && (pad_we || step_ok);
		mem_waddr = wr_q[vlrq_pkg::ADDR_W-1:0];
		mem_wdata = step_ok ? {1'b0, vlrq_pkg::LEN_W'(len_q)} :
			{1'b1, vlrq_pkg::LEN_W'(lim - w)};
		// The read address follows the read offset, so the header under it
		// arrives from the registered read port in the next cycle, also after a wrap.
		mem_raddr = rd_q[vlrq_pkg::ADDR_W-1:0];
	end

	vlrq_ram #(
		.WIDTH(vlrq_pkg::HDR_W),
		.DEPTH(vlrq_pkg::RING_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= vlrq_pkg::ST_IDLE;
			ring_length_q <= vlrq_pkg::RING_LEN_RESET;
			wr_q          <= vlrq_pkg::OFF_W'(vlrq_pkg::CONTROL_BYTES);
			rd_q          <= vlrq_pkg::OFF_W'(vlrq_pkg::CONTROL_BYTES);
			cnt_q         <= '0;
			pass_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				ring_length_q <= ring_length;
			end
			if (accept) begin
				pass_q <= 1'b0;
			end else if (adv && retry) begin
				pass_q <= 1'b1;
			end
			if (adv) begin
				if (wrap_w) begin
					wr_q <= vlrq_pkg::OFF_W'(vlrq_pkg::CONTROL_BYTES);
				end else if (state_q == vlrq_pkg::ST_PUSH && step_ok) begin
					wr_q <= vlrq_pkg::OFF_W'(w + lenx);
				end
				if (wrap_r) begin
					rd_q <= vlrq_pkg::OFF_W'(vlrq_pkg::CONTROL_BYTES);
				end else if (state_q == vlrq_pkg::ST_POP_EV && step_ok) begin
					rd_q <= vlrq_pkg::OFF_W'(r + word_len);
				end
				if (step_ok) begin
					if (state_q == vlrq_pkg::ST_PUSH && cnt_q != vlrq_pkg::COUNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (state_q == vlrq_pkg::ST_POP_EV && cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			if (adv && done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			len_q <= push_length;
		end
		if (adv && done) begin
			ok_q <= step_ok;
			if (!step_ok) begin
				offset_q <= '0;
				length_q <= '0;
				count_q  <= cnt_q;
			end else if (state_q == vlrq_pkg::ST_PUSH) begin
				offset_q <= vlrq_pkg::FIELD_W'(w);
				length_q <= len_q;
				count_q  <= (cnt_q != vlrq_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
			end else begin
				offset_q <= vlrq_pkg::FIELD_W'(r);
				length_q <= mem_rdata[vlrq_pkg::FIELD_W-1:0];
				count_q  <= (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign block_offset = offset_q;
	assign block_length = length_q;
	assign block_count  = count_q;

	// The header RAM is never written while a pop is being worked on.
	a_no_write_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vlrq_pkg::ST_POP_RD || state_q == vlrq_pkg::ST_POP_EV) |-> !mem_we)
		else $error("header RAM written during a pop");

	// The push evaluation state must match the command that was accepted.
	a_state_matches_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vlrq_pkg::ST_PUSH) |-> (cmd_q == vlrq_pkg::CMD_PUSH))
		else $error("push evaluation for a pop command");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && done) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// A failed result carries no offset and no length.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (offset_q == '0 && length_q == '0))
		else $error("failed result with payload");

	// A successful pop lowers the block count unless it was already zero.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && done && step_ok && state_q == vlrq_pkg::ST_POP_EV && cnt_q != '0)
		|=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("block count not decremented on pop");

endmodule

// ===== rtl/vlrq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vlrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for variable_length_ring_queue_top: directed and random
// push/pop beats checked against a built-in model of the ring bookkeeping.
// Depends on vlrq_pkg and the queue RTL (top level and header RAM).
module testbench;
	import vlrq_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS   = 230;
	localparam int PHASE_COUNT   = 8;
	localparam int IDLE_PCT      = 68;
	localparam int BOTH_IDLE_PCT = 36;
	localparam int PAD_BIT       = LEN_W;
	localparam int LEN_FIELD_MAX = (1 << FIELD_W) - 1;

	typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] count;
	} outcome_t;

	typedef struct {
		cmd_t               op;
		logic [FIELD_W-1:0] length;
		bit                 typed;
		outcome_t           want;
	} step_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   ring_length  = RING_LEN_RESET;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               command      = CMD_PUSH;
	logic [FIELD_W-1:0] push_length  = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic               ok;
	logic [FIELD_W-1:0] block_offset;
	logic [FIELD_W-1:0] block_length;
	logic [FIELD_W-1:0] block_count;

	// Model state: offsets, held count and the header words, as the block keeps them.
	logic [CFG_W-1:0]   ring_setting = RING_LEN_RESET;
	logic [OFF_W-1:0]   wr_pos       = OFF_W'(CONTROL_BYTES);
	logic [OFF_W-1:0]   rd_pos       = OFF_W'(CONTROL_BYTES);
	logic [FIELD_W-1:0] blocks_held  = '0;
	bit   [HDR_W-1:0]   header_words [RING_BYTES];
	bit                 header_written [RING_BYTES];

	outcome_t pending_outcomes [$];
	int gap_pct     = 0;
	int stall_pct   = 0;
	int mismatches  = 0;
	int quiet_cycles = 0;

	// Hand-checked opening sequence; untyped rows are left to the model.
	step_t directed_plan [24] = '{
		'{CMD_POP,  12'd0,    1'b1, '{1'b0, 12'd0,  12'd0, 12'd0}}, // empty ring
		'{CMD_PUSH, 12'd0,    1'b1, '{1'b0, 12'd0,  12'd0, 12'd0}}, // zero length
		'{CMD_PUSH, 12'd7,    1'b1, '{1'b0, 12'd0,  12'd0, 12'd0}}, // shorter than a header
		'{CMD_PUSH, 12'd4095, 1'b1, '{1'b0, 12'd0,  12'd0, 12'd0}}, // wrap, start unpopped
		'{CMD_PUSH, 12'd8,    1'b1, '{1'b1, 12'd16, 12'd8, 12'd1}},
		'{CMD_POP,  12'd0,    1'b1, '{1'b1, 12'd16, 12'd8, 12'd0}},
		'{CMD_POP,  12'd0,    1'b1, '{1'b0, 12'd0,  12'd0, 12'd0}},
		'{CMD_PUSH, 12'd4000, 1'b0, '0},
		'{CMD_PUSH, 12'd72,   1'b0, '0},                            // ends exactly at ring end
		'{CMD_PUSH, 12'd7,    1'b1, '{1'b0, 12'd0,  12'd0, 12'd1}},
		'{CMD_POP,  12'd0,    1'b0, '0},                            // read ahead of wrapped write
		'{CMD_POP,  12'd0,    1'b0, '0},                            // padding skipped
		'{CMD_PUSH, 12'd8,    1'b0, '0},
		'{CMD_PUSH, 12'd8,    1'b0, '0},
		'{CMD_POP,  12'd0,    1'b0, '0},
		'{CMD_POP,  12'd0,    1'b0, '0},
		'{CMD_PUSH, 12'd4058, 1'b0, '0},                            // leaves six bytes of tail
		'{CMD_POP,  12'd0,    1'b0, '0},
		'{CMD_PUSH, 12'd8,    1'b0, '0},                            // no room for padding
		'{CMD_POP,  12'd0,    1'b0, '0},                            // short tail skipped
		'{CMD_PUSH, 12'd4095, 1'b0, '0},
		'{CMD_POP,  12'd0,    1'b0, '0},
		'{CMD_PUSH, 12'd2048, 1'b0, '0},
		'{CMD_POP,  12'd0,    1'b0, '0}
	};

	variable_length_ring_queue_top dut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int span();
		return (ring_setting > RING_BYTES) ? RING_BYTES : int'(ring_setting);
	endfunction

	function automatic void store_header(logic [OFF_W-1:0] at, logic [HDR_W-1:0] word);
		header_words[at % RING_BYTES]   = word;
		header_written[at % RING_BYTES] = 1'b1;
	endfunction

	function automatic outcome_t predict_push(logic [FIELD_W-1:0] len);
		outcome_t res;
		int lim;
		res = '0;
		lim = span();
		res.count = blocks_held;
		if (len < HEADER_BYTES)
			return res;
		for (int pass = 0; pass < 2; pass++) begin
			if (wr_pos >= rd_pos) begin
				if (int'(wr_pos) + int'(len) >= lim) begin
					// Leave a padding header where one fits, then retry from the start.
					if (int'(wr_pos) + HEADER_BYTES <= lim)
						store_header(wr_pos, {1'b1, LEN_W'(lim - int'(wr_pos))});
					if (rd_pos == CONTROL_BYTES)
						return res;
					wr_pos = OFF_W'(CONTROL_BYTES);
					continue;
				end
			end else if (int'(wr_pos) + int'(len) >= int'(rd_pos)) begin
				return res;
			end
			store_header(wr_pos, {1'b0, LEN_W'(len)});
			res.ok     = 1'b1;
			res.offset = wr_pos[FIELD_W-1:0];
			res.length = len;
			wr_pos     = wr_pos + len;
			if (blocks_held != COUNT_MAX)
				blocks_held++;
			res.count = blocks_held;
			return res;
		end
		return res;
	endfunction

	function automatic outcome_t predict_pop();
		outcome_t res;
		bit [HDR_W-1:0] word;
		res = '0;
		res.count = blocks_held;
		for (int pass = 0; pass < 2; pass++) begin
			if (wr_pos > rd_pos) begin
				if (int'(wr_pos) < int'(rd_pos) + HEADER_BYTES)
					return res;
			end else if (wr_pos < rd_pos) begin
				if (span() < int'(rd_pos) + HEADER_BYTES
						|| header_words[rd_pos % RING_BYTES][PAD_BIT]) begin
					rd_pos = OFF_W'(CONTROL_BYTES);
					continue;
				end
			end else begin
				return res;
			end
			word       = header_words[rd_pos % RING_BYTES];
			res.ok     = 1'b1;
			res.offset = rd_pos[FIELD_W-1:0];
			res.length = word[FIELD_W-1:0];
			rd_pos     = rd_pos + word[LEN_W-1:0];
			if (blocks_held != '0)
				blocks_held--;
			res.count = blocks_held;
			return res;
		end
		return res;
	endfunction

	function automatic outcome_t predict_outcome(cmd_t op, logic [FIELD_W-1:0] len);
		if (op == CMD_PUSH)
			return predict_push(len);
		return predict_pop();
	endfunction

	// True when a pop now would look at a header slot that no push has written.
	function automatic bit pop_reads_blank();
		logic [OFF_W-1:0] at;
		at = rd_pos;
		for (int pass = 0; pass < 2; pass++) begin
			if (wr_pos > at) begin
				return (int'(wr_pos) >= int'(at) + HEADER_BYTES)
					&& !header_written[at % RING_BYTES];
			end else if (wr_pos < at) begin
				if (span() < int'(at) + HEADER_BYTES) begin
					at = OFF_W'(CONTROL_BYTES);
					continue;
				end
				if (!header_written[at % RING_BYTES])
					return 1'b1;
				if (!header_words[at % RING_BYTES][PAD_BIT])
					return 1'b0;
				at = OFF_W'(CONTROL_BYTES);
			end else begin
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	// Mostly lengths that let several blocks share the ring, with some short,
	// oversized and exact-fit lengths mixed in.
	function automatic logic [FIELD_W-1:0] draw_push_length();
		int lim, roll, top, tail;
		lim  = span();
		roll = $urandom_range(99);
		top  = (lim / 6 > HEADER_BYTES) ? lim / 6 : HEADER_BYTES;
		tail = lim - int'(wr_pos);
		if (roll < 78)
			return FIELD_W'($urandom_range(top, HEADER_BYTES));
		if (roll < 86)
			return FIELD_W'($urandom_range(HEADER_BYTES - 1, 0));
		if (roll < 90 && tail > 0 && tail <= LEN_FIELD_MAX)
			return FIELD_W'(tail);
		if (roll < 95)
			return FIELD_W'($urandom_range(LEN_FIELD_MAX, lim / 2));
		return FIELD_W'($urandom());
	endfunction

	task automatic set_flow(flow_t mode);
		case (mode)
			FLOW_FREE: begin gap_pct = 0; stall_pct = 0; end
			FLOW_SENDER_IDLE: begin gap_pct = IDLE_PCT; stall_pct = 0; end
			FLOW_RECEIVER_STALL: begin gap_pct = 0; stall_pct = IDLE_PCT; end
			default: begin gap_pct = BOTH_IDLE_PCT; stall_pct = BOTH_IDLE_PCT; end
		endcase
	endtask

	// Returns in the time step of acceptance with valid still high, so the
	// caller either presents the next beat or lowers valid in that same step.
	task automatic send_command(cmd_t op, logic [FIELD_W-1:0] len, bit typed, outcome_t want);
		outcome_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= op;
		push_length <= len;
		do @(posedge clk); while (!in_ready);
		predicted = predict_outcome(op, len);
		pending_outcomes.push_back(typed ? want : predicted);
	endtask

	task automatic wait_for_results();
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_ring_length(logic [CFG_W-1:0] value);
		cfg_valid   <= 1'b1;
		ring_length <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		ring_setting = value;
	endtask

	// Result side: random back-pressure, comparison and the watchdog.
	always @(posedge clk) begin
		outcome_t want;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no command outstanding");
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, ok);
					mismatches++;
				end
				if (block_offset !== want.offset) begin
					$error("block_offset: expected %0d, actual %0d", want.offset, block_offset);
					mismatches++;
				end
				if (block_length !== want.length) begin
					$error("block_length: expected %0d, actual %0d", want.length, block_length);
					mismatches++;
				end
				if (block_count !== want.count) begin
					$error("block_count: expected %0d, actual %0d", want.count, block_count);
					mismatches++;
				end
			end
		end
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin
		logic [CFG_W-1:0] ring_plan [PHASE_COUNT];
		int bias;
		ring_plan = '{CFG_W'(64), CFG_W'(4096), {CFG_W{1'b1}}, CFG_W'(320),
			CFG_W'($urandom_range(4096, 64)), CFG_W'(1000), CFG_W'(128), CFG_W'(4096)};
		bias = 50;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs at the reset ring length.
		set_flow(FLOW_FREE);
		foreach (directed_plan[i])
			send_command(directed_plan[i].op, directed_plan[i].length,
				directed_plan[i].typed, directed_plan[i].want);
		in_valid <= 1'b0;
		wait_for_results();

		// Random phases; ring contents carry over from one ring length to the next.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_ring_length(ring_plan[p]);
			set_flow(flow_t'(p % 4));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Alternate filling and draining stretches so the ring wraps often.
				if (k % 40 == 0)
					bias = 30 + 20 * $urandom_range(2);
				if ($urandom_range(99) < bias || pop_reads_blank())
					send_command(CMD_PUSH, draw_push_length(), 1'b0, '0);
				else
					send_command(CMD_POP, FIELD_W'($urandom()), 1'b0, '0);
			end
			in_valid <= 1'b0;
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vlrq_pkg.sv
rtl/vlrq_ram.sv
rtl/variable_length_ring_queue_top.sv
verif/testbench.sv
